>>> src/bwc_pkg.sv
package bwc_pkg;

  localparam int unsigned TgtW     = 256;
  localparam int unsigned WordW    = 64;
  localparam int unsigned CompactW = 32;
  localparam int unsigned QDepth   = 2;

  localparam logic [7:0]  MaxSmallSize = 8'd3;
  localparam logic [22:0] MantByteMax  = 23'h0000ff;
  localparam logic [22:0] MantHalfMax  = 23'h00ffff;
  localparam logic [7:0]  SizeLimit2   = 8'd34;
  localparam logic [7:0]  SizeLimit1   = 8'd33;
  localparam logic [7:0]  SizeLimit0   = 8'd32;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_NEG  = 2'd1,
    ST_OVF  = 2'd2,
    ST_ZERO = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_DIV  = 2'd1,
    BK_INC  = 2'd2,
    BK_OUT  = 2'd3
  } back_state_e;

  // one decoded job handed from front to back
  typedef struct packed {
    logic [TgtW-1:0] target;
    status_e         status;
  } job_t;

endpackage

>>> src/bwc_front.sv
module bwc_front (
  input  logic [bwc_pkg::CompactW-1:0] compact_bits_i,
  output bwc_pkg::job_t                job_o
);
  import bwc_pkg::*;

  logic [7:0]      size;
  logic            sign;
  logic [22:0]     mant_raw;
  logic [22:0]     mant;
  logic [7:0]      sh;
  logic [TgtW-1:0] target;
  logic            neg;
  logic            ovf;

  // decode size/sign/mantissa into a 256-bit target
  always_comb begin
    size     = compact_bits_i[31:24];
    sign     = compact_bits_i[23];
    mant_raw = compact_bits_i[22:0];
    sh       = size - MaxSmallSize;
    if (size <= MaxSmallSize) begin
      mant   = mant_raw >> {(2'(MaxSmallSize[1:0] - size[1:0])), 3'b000};
      target = {{(TgtW-23){1'b0}}, mant};
    end else begin
      mant = mant_raw;
      if (sh >= 8'd32) begin
        target = '0;
      end else begin
        target = {{(TgtW-23){1'b0}}, mant} << {sh[4:0], 3'b000};
      end
    end
  end

  // classify, first reason wins
  always_comb begin
    neg = (mant != '0) && sign;
    ovf = (mant != '0) && ((size > SizeLimit2) ||
                           ((mant > MantByteMax) && (size > SizeLimit1)) ||
                           ((mant > MantHalfMax) && (size > SizeLimit0)));
    job_o.target = target;
    if (neg) begin
      job_o.status = ST_NEG;
    end else if (ovf) begin
      job_o.status = ST_OVF;
    end else if (target == '0) begin
      job_o.status = ST_ZERO;
    end else begin
      job_o.status = ST_OK;
    end
  end

endmodule

>>> src/bwc_queue.sv
module bwc_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  bwc_pkg::job_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output bwc_pkg::job_t pop_data_o
);
  import bwc_pkg::*;

  job_t                      mem_q [QDepth];
  logic [$clog2(QDepth)-1:0] wr_ptr_q, rd_ptr_q;
  logic [$clog2(QDepth):0]   count_q;

  assign full_o     = (count_q == ($clog2(QDepth)+1)'(QDepth));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i && !full_o) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i && !empty_o) rd_ptr_q <= rd_ptr_q + 1'b1;
      count_q <= count_q + ($clog2(QDepth)+1)'(push_i && !full_o)
                         - ($clog2(QDepth)+1)'(pop_i && !empty_o);
    end
  end

endmodule

>>> src/bwc_back.sv
module bwc_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      job_valid_i,
  input  bwc_pkg::job_t             job_i,
  output logic                      job_pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [bwc_pkg::WordW-1:0] out_word_o,
  output logic [1:0]                out_index_o,
  output logic                      out_last_o,
  output bwc_pkg::status_e          out_status_o
);
  import bwc_pkg::*;

  back_state_e     state_q, state_d;
  logic [TgtW-1:0] rem_q, rem_d;
  logic [TgtW-1:0] quo_q, quo_d;
  logic [TgtW:0]   den_q, den_d;
  logic [7:0]      step_q, step_d;
  logic [1:0]      idx_q, idx_d;
  status_e         status_q, status_d;

  logic [TgtW:0]   rem_sh;
  logic [TgtW+1:0] diff;
  logic            ge;

  // one restoring step: shift in next dividend bit, try subtract
  always_comb begin
    rem_sh = {rem_q, quo_q[TgtW-1]};
    diff   = {1'b0, rem_sh} - {1'b0, den_q};
    ge     = !diff[TgtW+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    den_q    <= den_d;
    step_q   <= step_d;
    idx_q    <= idx_d;
    status_q <= status_d;
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    den_d     = den_q;
    step_d    = step_q;
    idx_d     = idx_q;
    status_d  = status_q;
    job_pop_o = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          status_d  = job_i.status;
          rem_d     = '0;
          quo_d     = ~job_i.target;
          den_d     = {1'b0, job_i.target} + (TgtW+1)'(1);
          step_d    = '0;
          idx_d     = '0;
          if (job_i.status == ST_OK) begin
            state_d = BK_DIV;
          end else begin
            quo_d   = '0;
            state_d = BK_OUT;
          end
        end
      end
      BK_DIV: begin
        rem_d  = ge ? diff[TgtW-1:0] : rem_sh[TgtW-1:0];
        quo_d  = {quo_q[TgtW-2:0], ge};
        step_d = step_q + 8'd1;
        if (step_q == 8'hff) state_d = BK_INC;
      end
      BK_INC: begin
        quo_d   = quo_q + TgtW'(1);
        state_d = BK_OUT;
      end
      BK_OUT: begin
        if (out_ready_i) begin
          quo_d = quo_q >> WordW;
          idx_d = idx_q + 2'd1;
          if (idx_q == 2'd3) state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  assign out_valid_o  = (state_q == BK_OUT);
  assign out_word_o   = quo_q[WordW-1:0];
  assign out_index_o  = idx_q;
  assign out_last_o   = (idx_q == 2'd3);
  assign out_status_o = status_q;

endmodule

>>> src/block_work_from_compact_target.sv
// Channel   | Dir | Payload
// s_axis    | in  | tdata[31:0] compact_bits
// m_axis    | out | tdata[63:0] work_word, tuser[1:0] word_index,
//           |     | tuser[3:2] status, tlast last_word
// Steps: a valid target takes 256 division steps on one 257-bit subtractor,
// then an increment and four output words.
// Invalid targets skip the divider and the increment and emit four zero words.
// A two-entry job queue lets the decoder take new targets while the divider runs.
// Reset clears control only; output stalls hold the back end in place.
module block_work_from_compact_target (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [bwc_pkg::CompactW-1:0] s_axis_tdata_i,  // [31:0] compact_bits
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [bwc_pkg::WordW-1:0]    m_axis_tdata_o,  // [63:0] work_word
  output logic [3:0]                   m_axis_tuser_o,  // [1:0] word_index, [3:2] status
  output logic                         m_axis_tlast_o   // last_word
);
  import bwc_pkg::*;

  job_t    dec_job, q_job;
  logic    q_full, q_empty, q_pop;
  logic [1:0] idx;
  status_e status;

  bwc_front u_front (
    .compact_bits_i (s_axis_tdata_i),
    .job_o          (dec_job)
  );

  assign s_axis_tready_o = !q_full;

  bwc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s_axis_tvalid_i),
    .push_data_i (dec_job),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .pop_data_o  (q_job)
  );

  bwc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (!q_empty),
    .job_i        (q_job),
    .job_pop_o    (q_pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_word_o   (m_axis_tdata_o),
    .out_index_o  (idx),
    .out_last_o   (m_axis_tlast_o),
    .out_status_o (status)
  );

  assign m_axis_tuser_o = {status, idx};

endmodule

>>> src/bwc_checker.sv
module bwc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [63:0] m_axis_tdata_o,
  input logic [3:0]  m_axis_tuser_o,
  input logic        m_axis_tlast_o
);
  import bwc_pkg::*;

  // tlast marks exactly the top slice
  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tlast_o == (m_axis_tuser_o[1:0] == 2'd3)))
    else $error("tlast disagrees with word index");

  // invalid targets carry zero work
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o[3:2] != ST_OK)) |-> (m_axis_tdata_o == '0))
    else $error("nonzero work on invalid target");

  // slice index steps by one within a run
  a_idx_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o) |=>
      (m_axis_tvalid_o && (m_axis_tuser_o[1:0] == $past(m_axis_tuser_o[1:0]) + 2'd1)))
    else $error("slice index skipped");

  // stalled transaction holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)))
    else $error("output changed under stall");

endmodule

bind block_work_from_compact_target bwc_checker u_bwc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

>>> dv/block_work_from_compact_target_tb.sv
`timescale 1ns / 100ps

module block_work_from_compact_target_tb;
  import bwc_pkg::*;

  localparam int unsigned NumRandom = 460;
  localparam int unsigned CycleLimit = 1500000;

  // one output transaction
  typedef struct packed {
    logic [63:0] word;
    logic [1:0]  index;
    logic        last;
    status_e     status;
  } slice_t;

  // directed row: compact word, and a fixed status/work where it is obvious
  typedef struct {
    logic [31:0] bits;
    logic        fixed;
    status_e     status;
  } row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid_i;
  logic                s_axis_tready_o;
  logic [CompactW-1:0] s_axis_tdata_i;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i;
  logic [WordW-1:0]    m_axis_tdata_o;
  logic [3:0]          m_axis_tuser_o;
  logic                m_axis_tlast_o;

  slice_t  work_q[$];
  int      errors;
  int      cycles;
  int      send_idle_pct;
  int      recv_stall_pct;

  block_work_from_compact_target i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o,
    .m_axis_tuser_o,
    .m_axis_tlast_o
  );

  always #5 clk_i = ~clk_i;

  // decode the compact word and compute floor(2^256/(target+1))
  function automatic void predict_work(input logic [31:0] c, output status_e st,
                                       output logic [255:0] work);
    logic [7:0]   size;
    logic [22:0]  mant;
    logic [255:0] tgt;
    logic [255:0] num;
    logic [256:0] den;
    logic [256:0] rem;
    logic         neg;
    logic         ovf;
    size = c[31:24];
    mant = c[22:0];
    work = '0;
    if (size <= 3) begin
      mant = mant >> (8 * (3 - size));
      tgt  = 256'(mant);
    end else if (8 * (int'(size) - 3) >= 256) begin
      tgt = '0;
    end else begin
      tgt = 256'(mant) << (8 * (size - 3));
    end
    neg = (mant != 0) && c[23];
    ovf = (mant != 0) && (size > 34 || (mant > 23'hff && size > 33) ||
                          (mant > 23'hffff && size > 32));
    if (neg) st = ST_NEG;
    else if (ovf) st = ST_OVF;
    else if (tgt == '0) st = ST_ZERO;
    else begin
      st  = ST_OK;
      num = ~tgt;
      den = {1'b0, tgt} + 257'd1;
      rem = '0;
      for (int i = 255; i >= 0; i--) begin
        rem = {rem[255:0], num[i]};
        if (rem >= den) begin
          rem = rem - den;
          work[i] = 1'b1;
        end
      end
      work = work + 256'd1;
    end
  endfunction

  task automatic queue_slices(input status_e st, input logic [255:0] work);
    slice_t s;
    for (int k = 0; k < 4; k++) begin
      s.word   = work[64*k +: 64];
      s.index  = 2'(k);
      s.last   = (k == 3);
      s.status = st;
      work_q.push_back(s);
    end
  endtask

  // one compact word over the input stream; expectations queued on acceptance
  task automatic send_target(input logic [31:0] c, input logic fixed, input status_e fst);
    status_e      st;
    logic [255:0] work;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= c;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_work(c, st, work);
    if (fixed) begin
      st   = fst;
      work = '0;
    end
    queue_slices(st, work);
  endtask

  // random receiver stalls
  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // output checker
  always @(posedge clk_i) begin
    slice_t got;
    slice_t exp_s;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = {m_axis_tdata_o, m_axis_tuser_o[1:0], m_axis_tlast_o,
             status_e'(m_axis_tuser_o[3:2])};
      if (work_q.size() == 0) begin
        $display("%0t: unexpected transaction %h", $time, got);
        errors++;
      end else begin
        exp_s = work_q.pop_front();
        if (got.word !== exp_s.word || got.index !== exp_s.index ||
            got.last !== exp_s.last || got.status !== exp_s.status) begin
          $display("%0t: mismatch expected %h/%0d/%0d/%0d actual %h/%0d/%0d/%0d",
                   $time, exp_s.word, exp_s.index, exp_s.last, exp_s.status,
                   got.word, got.index, got.last, got.status);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // random compact word: mostly plausible sizes, some raw noise
  function automatic logic [31:0] rand_bits();
    logic [31:0] c;
    c = $urandom;
    case ($urandom_range(9))
      0, 1:    c[31:24] = 8'($urandom_range(0, 3));
      2, 3, 4: c[31:24] = 8'($urandom_range(4, 32));
      5:       c[31:24] = 8'($urandom_range(32, 36));
      default: ;
    endcase
    if ($urandom_range(3) != 0) c[23] = 1'b0;
    if ($urandom_range(9) == 0) c[22:8] = '0;
    return c;
  endfunction

  row_t rows[] = '{
    '{32'h00000000, 1'b1, ST_ZERO},
    '{32'h03000000, 1'b1, ST_ZERO},
    '{32'h00ffffff, 1'b1, ST_ZERO},
    '{32'h01003456, 1'b1, ST_ZERO},
    '{32'h01803456, 1'b1, ST_ZERO},
    '{32'h01123456, 1'b0, ST_OK},
    '{32'h02123456, 1'b0, ST_OK},
    '{32'h03000001, 1'b0, ST_OK},
    '{32'h037fffff, 1'b0, ST_OK},
    '{32'h04923456, 1'b1, ST_NEG},
    '{32'hff800001, 1'b1, ST_NEG},
    '{32'h1d00ffff, 1'b0, ST_OK},
    '{32'h207fffff, 1'b0, ST_OK},
    '{32'h21010000, 1'b1, ST_OVF},
    '{32'h2100ffff, 1'b0, ST_OK},
    '{32'h22000100, 1'b1, ST_OVF},
    '{32'h220000ff, 1'b0, ST_OK},
    '{32'h23000001, 1'b1, ST_OVF},
    '{32'hff7fffff, 1'b1, ST_OVF},
    '{32'hff000000, 1'b1, ST_ZERO},
    '{32'h45000001, 1'b1, ST_OVF},
    '{32'h05800000, 1'b1, ST_ZERO},
    '{32'h04000001, 1'b0, ST_OK}
  };

  initial begin
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_target(rows[i].bits, rows[i].fixed, rows[i].status);

    // random part in four pressure phases
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = (p == 1) ? 74 : (p == 3) ? 24 : 0;
      recv_stall_pct = (p == 2) ? 74 : (p == 3) ? 24 : 0;
      for (int n = 0; n < NumRandom / 4; n++) send_target(rand_bits(), 1'b0, ST_OK);
    end
    s_axis_tvalid_i <= 1'b0;

    while (work_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
